FILE: rtl/assert_macros.svh
// assertion macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define BILD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define BILD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bild_pkg.sv
// types, codes and opcode length table for the bytecode length decoder
package bild_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_OPERANDS,
        PH_WIDE,
        PH_PAD,
        PH_HEADER,
        PH_TABLE
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_BAD_WIDE  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_NEG_RANGE = 3'd4;

    // kinds 0..4 are operand byte counts, the rest are special
    localparam logic [3:0] K_MAX_FIXED = 4'd4;
    localparam logic [3:0] K_INV       = 4'd5;
    localparam logic [3:0] K_TSW       = 4'd6;
    localparam logic [3:0] K_LSW       = 4'd7;
    localparam logic [3:0] K_WIDE      = 4'd8;

    localparam logic [7:0] OP_TABLESWITCH = 8'hAA;
    localparam logic [7:0] OP_IINC        = 8'h84;

    localparam logic [16:0] LEN_MAX = 17'h1FFFF;

    localparam int DATA_IN_BITS  = 8;
    localparam int DATA_OUT_BITS = 48;

    typedef struct packed {
        logic [15:0] start_offset;
        logic [7:0]  opcode;
        logic [16:0] byte_length;
        logic [2:0]  status;
    } t_result;

    function automatic logic [3:0] op_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b) inside
            8'h10, 8'h12, [8'h15:8'h19], [8'h36:8'h3A], 8'hA9, 8'hBC: k = 4'd1;
            8'h11, 8'h13, 8'h14, 8'h84, [8'h99:8'hA8], [8'hB2:8'hB8],
            8'hBB, 8'hBD, 8'hC0, 8'hC1, 8'hC6, 8'hC7:                    k = 4'd2;
            8'hC5:                                                      k = 4'd3;
            8'hB9, 8'hC8, 8'hC9:                                        k = 4'd4;
            8'hBA, [8'hCA:8'hFF]:                                       k = K_INV;
            8'hAA:                                                      k = K_TSW;
            8'hAB:                                                      k = K_LSW;
            8'hC4:                                                      k = K_WIDE;
            default:                                                    k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/bild_in_stage.sv
// input register for code bytes
module bild_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       i_out_free,
    output logic       o_advance,
    output logic [7:0] o_byte,
    output logic       o_last
);
    import bild_pkg::*;

    logic                    r_valid;
    logic [DATA_IN_BITS-1:0] r_byte;
    logic                    r_last;
    logic                    w_take;

    assign o_advance     = r_valid && i_out_free;
    assign s_axis_tready = !r_valid || i_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign o_byte        = r_byte;
    assign o_last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

endmodule

FILE: rtl/bild_decode.sv
// instruction boundary state machine with per-byte decode
`include "assert_macros.svh"

module bild_decode #(
    parameter int OFFSET_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_wr_data,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_res_valid,
    output bild_pkg::t_result o_res
);
    import bild_pkg::*;

    logic [1:0]             r_base;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    t_phase                 r_phase, n_phase;
    logic [34:0]            r_remain, n_remain;
    logic [31:0]            r_shift, n_shift;
    logic [31:0]            r_low, n_low;
    logic [3:0]             r_wcnt, n_wcnt;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [7:0]             r_op, n_op;
    logic                   r_skip, n_skip;

    logic                   w_done;
    logic [2:0]             w_status;
    logic [3:0]             w_kind;
    logic [1:0]             w_pos;
    logic [1:0]             w_pad;
    logic [34:0]            w_rem_dec;
    logic [31:0]            w_shift_nx;
    logic [3:0]             w_wcnt_nx;
    logic [32:0]            w_range;
    logic [32:0]            w_count;
    logic [OFFSET_BITS-1:0] w_span;
    logic [OFFSET_BITS:0]   w_len_full;
    logic [32:0]            w_len_ext;
    logic [31:0]            w_start_ext;
    logic                   w_counted_ph;
    logic                   w_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 2'd0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    assign w_kind     = op_kind(i_byte);
    // offset of the byte after the opcode, modulo 4, from the code base
    assign w_pos      = r_base + r_offset[1:0] + 2'd1;
    assign w_pad      = 2'd0 - w_pos;
    assign w_rem_dec  = (r_remain != 35'd0) ? r_remain - 35'd1 : r_remain;
    assign w_shift_nx = {r_shift[23:0], i_byte};
    assign w_wcnt_nx  = r_wcnt + 4'd1;
    // signed high minus low, sign bit flags an empty range
    assign w_range    = {w_shift_nx[31], w_shift_nx} - {r_low[31], r_low};
    assign w_count    = w_range + 33'd1;

    always_comb begin
        n_offset    = r_offset;
        n_phase     = r_phase;
        n_remain    = r_remain;
        n_shift     = r_shift;
        n_low       = r_low;
        n_wcnt      = r_wcnt;
        n_start     = r_start;
        n_op        = r_op;
        n_skip      = r_skip;
        w_done      = 1'b0;
        w_status    = ST_OK;
        o_res_valid = 1'b0;

        if (!r_skip) begin
            unique case (r_phase)
                PH_OPCODE: begin
                    n_start = r_offset;
                    n_op    = i_byte;
                    if (w_kind == 4'd0) begin
                        w_done = 1'b1;
                    end else if (w_kind <= K_MAX_FIXED) begin
                        n_remain = 35'(w_kind);
                        n_phase  = PH_OPERANDS;
                    end else if (w_kind == K_INV) begin
                        w_done   = 1'b1;
                        w_status = ST_INVALID;
                    end else if (w_kind == K_TSW || w_kind == K_LSW) begin
                        n_wcnt  = 4'd0;
                        n_shift = 32'd0;
                        if (w_pad != 2'd0) begin
                            n_remain = 35'(w_pad);
                            n_phase  = PH_PAD;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_phase = PH_WIDE;
                    end
                end
                PH_OPERANDS, PH_TABLE: begin
                    n_remain = w_rem_dec;
                    if (w_rem_dec == 35'd0) begin
                        w_done = 1'b1;
                    end
                end
                PH_WIDE: begin
                    if (i_byte == OP_IINC) begin
                        n_remain = 35'd4;
                        n_phase  = PH_OPERANDS;
                    end else begin
                        w_done   = 1'b1;
                        w_status = ST_BAD_WIDE;
                    end
                end
                PH_PAD: begin
                    n_remain = w_rem_dec;
                    if (w_rem_dec == 35'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    n_shift = w_shift_nx;
                    n_wcnt  = w_wcnt_nx;
                    if (w_wcnt_nx == 4'd8) begin
                        if (r_op == OP_TABLESWITCH) begin
                            n_low = w_shift_nx;
                        end else if (w_shift_nx[31]) begin
                            w_done   = 1'b1;
                            w_status = ST_NEG_RANGE;
                        end else if (w_shift_nx == 32'd0) begin
                            w_done = 1'b1;
                        end else begin
                            // eight bytes per match-offset pair
                            n_remain = {w_shift_nx, 3'b000};
                            n_phase  = PH_TABLE;
                        end
                    end else if (w_wcnt_nx >= 4'd12) begin
                        if (w_range[32]) begin
                            w_done   = 1'b1;
                            w_status = ST_NEG_RANGE;
                        end else begin
                            n_remain = {w_count, 2'b00};
                            n_phase  = PH_TABLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase

            if (w_done) begin
                o_res_valid = 1'b1;
                n_phase     = PH_OPCODE;
                if (w_status != ST_OK && !i_last) begin
                    n_skip = 1'b1;
                end
            end else if (i_last && n_phase != PH_OPCODE) begin
                o_res_valid = 1'b1;
                w_status    = ST_TRUNCATED;
            end
        end

        if (i_last) begin
            n_phase  = PH_OPCODE;
            n_offset = '0;
            n_skip   = 1'b0;
        end else begin
            n_offset = r_offset + OFFSET_BITS'(1);
        end
    end

    // length from the offset difference, saturated to the field width
    assign w_span      = r_offset - n_start;
    assign w_len_full  = {1'b0, w_span} + (OFFSET_BITS+1)'(1);
    assign w_len_ext   = 33'(w_len_full);
    assign w_start_ext = 32'(n_start);

    always_comb begin
        o_res.start_offset = w_start_ext[15:0];
        o_res.opcode       = n_op;
        o_res.byte_length  = (w_len_ext > 33'(LEN_MAX)) ? LEN_MAX : w_len_ext[16:0];
        o_res.status       = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_phase  <= PH_OPCODE;
            r_remain <= 35'd0;
            r_shift  <= 32'd0;
            r_low    <= 32'd0;
            r_wcnt   <= 4'd0;
            r_start  <= '0;
            r_op     <= 8'd0;
            r_skip   <= 1'b0;
        end else if (i_en) begin
            r_offset <= n_offset;
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_shift  <= n_shift;
            r_low    <= n_low;
            r_wcnt   <= n_wcnt;
            r_start  <= n_start;
            r_op     <= n_op;
            r_skip   <= n_skip;
        end
    end

    assign w_counted_ph = r_phase == PH_OPERANDS || r_phase == PH_PAD || r_phase == PH_TABLE;
    assign w_inv        = i_en && o_res_valid && w_status == ST_INVALID;

    `BILD_ASSERT_NEVER(a_skip_only_at_opcode, r_skip && r_phase != PH_OPCODE, "skip off opcode")
    `BILD_ASSERT(a_counted_phase_nonzero, w_counted_ph |-> r_remain != 35'd0, "zero count left")
    `BILD_ASSERT(a_header_count_bound, r_phase == PH_HEADER |-> r_wcnt < 4'd12, "header overran")
    `BILD_ASSERT(a_invalid_len_one, w_inv |-> o_res.byte_length == 17'd1, "bad invalid length")

endmodule

FILE: rtl/bild_out_stage.sv
// result register toward the output stream
module bild_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_res_valid,
    input  bild_pkg::t_result i_res,
    output logic              o_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata
);
    import bild_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = DATA_OUT_BITS'({r_res.status, r_res.byte_length,
                                           r_res.opcode, r_res.start_offset});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_res_valid;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/bytecode_instruction_length_decoder.sv
// top level of the bytecode instruction length decoder
//
//  port group      dir   payload
//  s_axis_*        in    code byte, tlast on the method's final byte
//  m_axis_*        out   start offset, opcode, length, status per instruction
//  i_cfg_wr_*      in    base address phase (code start address mod 4)
//
// one byte per cycle sustained unless m_axis_tready stalls; a byte waits in the
// input register, and its result, if any, is registered in the output register
// as the byte leaves; decode is one table lookup plus a 35-bit counter update
// synchronous active-low reset returns to opcode decode at offset zero
// a stalled m_axis_tready holds the result and backs up into s_axis_tready
module bytecode_instruction_length_decoder #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] start_offset, [23:16] opcode,
                                        // [40:24] byte_length, [43:41] status
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data
);
    import bild_pkg::*;

    logic       w_out_free;
    logic       w_advance;
    logic [7:0] w_byte;
    logic       w_last;
    logic       w_res_valid;
    t_result    w_res;

    bild_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_out_free    (w_out_free),
        .o_advance     (w_advance),
        .o_byte        (w_byte),
        .o_last        (w_last)
    );

    bild_decode #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_en          (w_advance),
        .i_byte        (w_byte),
        .i_last        (w_last),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    bild_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_res_valid   (w_res_valid),
        .i_res         (w_res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the bytecode instruction length decoder
module tb_top;
    import bild_pkg::*;

    localparam logic [7:0] OP_LOOKUPSWITCH = 8'hAB;
    localparam logic [7:0] OP_WIDE         = 8'hC4;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_PRINTED     = 50;

    typedef enum logic [1:0] {
        SEQ_BYTE,
        SEQ_CFG,
        SEQ_DRAIN,
        SEQ_HOLD
    } t_seq_kind;

    typedef struct {
        t_seq_kind   kind;
        logic [7:0]  data;
        logic        lst;
        int unsigned gap;
    } t_seq_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [7:0] code_byte
    logic        s_axis_tlast = 1'b0;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // [15:0] start_offset, [23:16] opcode,
                                          // [40:24] byte_length, [43:41] status
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_wr_data = 2'd0;

    bytecode_instruction_length_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decoder state as the block should hold it
    logic [1:0]  base_phase = 2'd0;
    logic [15:0] pc_ofs     = 16'd0;
    t_phase      phase      = PH_OPCODE;
    logic [34:0] remaining  = 35'd0;
    logic [31:0] hdr_word   = 32'd0;
    logic [31:0] range_lo   = 32'd0;
    logic [3:0]  hdr_count  = 4'd0;
    logic [15:0] ins_start  = 16'd0;
    logic [7:0]  ins_op     = 8'd0;
    logic        skipping   = 1'b0;

    t_result    decoded_instrs[$];
    t_seq_entry code_stream[$];

    int unsigned bytes_taken     = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned errors          = 0;
    int unsigned n_status[8];
    logic        hold_toggle = 1'b0;

    // operand byte count for fixed-length opcodes, special kinds otherwise
    function automatic logic [3:0] instr_kind(input logic [7:0] op);
        if (op >= 8'hCA || op == 8'hBA) return K_INV;
        case (op)
            OP_TABLESWITCH:                                   return K_TSW;
            OP_LOOKUPSWITCH:                                  return K_LSW;
            OP_WIDE:                                          return K_WIDE;
            8'hC5:                                            return 4'd3;
            8'hB9, 8'hC8, 8'hC9:                              return 4'd4;
            8'h10, 8'h12, 8'hA9, 8'hBC:                       return 4'd1;
            8'h11, 8'h13, 8'h14, 8'h84, 8'hBB, 8'hBD,
            8'hC0, 8'hC1, 8'hC6, 8'hC7:                       return 4'd2;
            default: ;
        endcase
        if ((op >= 8'h15 && op <= 8'h19) || (op >= 8'h36 && op <= 8'h3A)) return 4'd1;
        if ((op >= 8'h99 && op <= 8'hA8) || (op >= 8'hB2 && op <= 8'hB8)) return 4'd2;
        return 4'd0;
    endfunction

    function automatic void record_instr(input logic [2:0] st);
        t_result r;
        r.start_offset = ins_start;
        r.opcode       = ins_op;
        // 16-bit offsets keep this below the 17-bit saturation point
        r.byte_length  = {1'b0, pc_ofs - ins_start} + 17'd1;
        r.status       = st;
        decoded_instrs.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        logic [3:0]         k;
        logic               done;
        logic [2:0]         st;
        logic [1:0]         pad;
        logic signed [32:0] lo_s;
        logic signed [32:0] hi_s;
        logic [32:0]        span;
        done = 1'b0;
        st   = ST_OK;
        if (skipping) begin
            if (lst) begin
                skipping = 1'b0;
                pc_ofs   = 16'd0;
                phase    = PH_OPCODE;
            end else begin
                pc_ofs = pc_ofs + 16'd1;
            end
            return;
        end
        case (phase)
            PH_OPCODE: begin
                k         = instr_kind(b);
                ins_start = pc_ofs;
                ins_op    = b;
                if (k == 4'd0) begin
                    done = 1'b1;
                end else if (k <= K_MAX_FIXED) begin
                    remaining = 35'(k);
                    phase     = PH_OPERANDS;
                end else if (k == K_INV) begin
                    done = 1'b1;
                    st   = ST_INVALID;
                end else if (k == K_TSW || k == K_LSW) begin
                    // align the header to a 4-byte boundary of the absolute address
                    pad       = 2'd0 - (base_phase + pc_ofs[1:0] + 2'd1);
                    hdr_count = 4'd0;
                    hdr_word  = 32'd0;
                    if (pad != 2'd0) begin
                        remaining = 35'(pad);
                        phase     = PH_PAD;
                    end else begin
                        phase = PH_HEADER;
                    end
                end else begin
                    phase = PH_WIDE;
                end
            end
            PH_OPERANDS, PH_TABLE: begin
                if (remaining != 0) remaining = remaining - 35'd1;
                if (remaining == 0) done = 1'b1;
            end
            PH_WIDE: begin
                if (b == OP_IINC) begin
                    remaining = 35'd4;
                    phase     = PH_OPERANDS;
                end else begin
                    done = 1'b1;
                    st   = ST_BAD_WIDE;
                end
            end
            PH_PAD: begin
                if (remaining != 0) remaining = remaining - 35'd1;
                if (remaining == 0) phase = PH_HEADER;
            end
            PH_HEADER: begin
                hdr_word  = {hdr_word[23:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count == 4'd8) begin
                    if (ins_op == OP_TABLESWITCH) begin
                        range_lo = hdr_word;
                    end else if (hdr_word[31]) begin
                        done = 1'b1;
                        st   = ST_NEG_RANGE;
                    end else if (hdr_word == 32'd0) begin
                        done = 1'b1;
                    end else begin
                        remaining = {hdr_word, 3'b000};
                        phase     = PH_TABLE;
                    end
                end else if (hdr_count >= 4'd12) begin
                    lo_s = {range_lo[31], range_lo};
                    hi_s = {hdr_word[31], hdr_word};
                    if (hi_s < lo_s) begin
                        done = 1'b1;
                        st   = ST_NEG_RANGE;
                    end else begin
                        span      = hi_s - lo_s;
                        remaining = ({2'b00, span} + 35'd1) << 2;
                        phase     = PH_TABLE;
                    end
                end
            end
            default: phase = PH_OPCODE;
        endcase

        if (done) begin
            record_instr(st);
            phase = PH_OPCODE;
            if (st != ST_OK && !lst) skipping = 1'b1;
        end else if (lst && phase != PH_OPCODE) begin
            record_instr(ST_TRUNCATED);
        end

        if (lst) begin
            phase    = PH_OPCODE;
            pc_ofs   = 16'd0;
            skipping = 1'b0;
        end else begin
            pc_ofs = pc_ofs + 16'd1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // ---------------- driver ----------------
    int unsigned gap_left  = 0;
    logic        gap_armed = 1'b0;
    int unsigned settle    = 0;

    always @(posedge i_clk) begin : byte_driver
        logic valid_n;
        logic cfg_n;
        valid_n = s_axis_tvalid;
        cfg_n   = 1'b0;
        if (!i_rst_n) begin
            valid_n = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
                valid_n = 1'b0;
            end
            if (!valid_n && code_stream.size() != 0) begin
                if (!gap_armed) begin
                    gap_left  = code_stream[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    case (code_stream[0].kind)
                        SEQ_BYTE: begin
                            valid_n = 1'b1;
                            s_axis_tdata <= code_stream[0].data;
                            s_axis_tlast <= code_stream[0].lst;
                            void'(code_stream.pop_front());
                            gap_armed = 1'b0;
                        end
                        SEQ_HOLD: begin
                            hold_toggle <= ~hold_toggle;
                            void'(code_stream.pop_front());
                            gap_armed = 1'b0;
                        end
                        default: begin
                            // wait until every instruction is out and the pipe is quiet
                            if (decoded_instrs.size() != 0) begin
                                settle = 0;
                            end else if (settle < SETTLE_CYCLES) begin
                                settle++;
                            end else begin
                                if (code_stream[0].kind == SEQ_CFG) begin
                                    cfg_n = 1'b1;
                                    i_cfg_wr_data <= code_stream[0].data[1:0];
                                    base_phase = code_stream[0].data[1:0];
                                    cfg_writes++;
                                end
                                settle = 0;
                                void'(code_stream.pop_front());
                                gap_armed = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
        s_axis_tvalid <= valid_n;
        i_cfg_wr_en   <= cfg_n;
    end

    // ---------------- monitor ----------------
    int unsigned rx_wait    = 0;
    int unsigned stall_left = 0;
    logic        hold_seen  = 1'b0;
    logic        rx_calm    = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        t_result got;
        logic    accepted;
        accepted = m_axis_tvalid && m_axis_tready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (accepted) begin
                got.start_offset = m_axis_tdata[15:0];
                got.opcode       = m_axis_tdata[23:16];
                got.byte_length  = m_axis_tdata[40:24];
                got.status       = m_axis_tdata[43:41];
                if (decoded_instrs.size() == 0) begin
                    report_mismatch("instruction with none pending", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = decoded_instrs.pop_front();
                    if (got.start_offset != want.start_offset)
                        report_mismatch("start_offset", 32'(got.start_offset),
                                        32'(want.start_offset));
                    if (got.opcode != want.opcode)
                        report_mismatch("opcode", 32'(got.opcode), 32'(want.opcode));
                    if (got.byte_length != want.byte_length)
                        report_mismatch("byte_length", 32'(got.byte_length),
                                        32'(want.byte_length));
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    n_status[want.status]++;
                end
                results_checked++;
                if (results_checked % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
            end
            if (hold_toggle != hold_seen) begin
                hold_seen  = hold_toggle;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stall_left != 0) stall_left--;
            else if (!accepted && rx_wait != 0) rx_wait--;
            m_axis_tready <= (stall_left == 0 && rx_wait == 0);
        end
    end

    // ---------------- watchdog ----------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0]  mbytes[$];
    int          last_start = 0;
    logic [1:0]  gen_base   = 2'd0;
    logic        tx_calm    = 1'b0;
    int unsigned n_queued   = 0;

    task automatic push_byte(input logic [7:0] b, input logic lst);
        t_seq_entry e;
        e.kind = SEQ_BYTE;
        e.data = b;
        e.lst  = lst;
        e.gap  = tx_calm ? 0 : $urandom_range(0, 14);
        code_stream.push_back(e);
        n_queued++;
    endtask

    task automatic push_marker(input t_seq_kind kind, input logic [7:0] value);
        t_seq_entry e;
        e.kind = kind;
        e.data = value;
        e.lst  = 1'b0;
        e.gap  = 0;
        code_stream.push_back(e);
    endtask

    task automatic set_base(input logic [1:0] value);
        gen_base = value;
        push_marker(SEQ_CFG, {6'd0, value});
    endtask

    task automatic add_rand(input int unsigned n);
        repeat (n) mbytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) mbytes.push_back(w[8*i +: 8]);
    endtask

    task automatic add_fixed(input logic [7:0] op);
        last_start = mbytes.size();
        mbytes.push_back(op);
        add_rand(32'(instr_kind(op)));
    endtask

    // w2 is the high bound and only used by tableswitch
    task automatic add_switch(input logic [7:0] op, input logic [31:0] w1,
                              input logic [31:0] w2, input int unsigned body);
        logic [1:0] pad;
        last_start = mbytes.size();
        pad = 2'd0 - (gen_base + 2'(mbytes.size()) + 2'd1);
        mbytes.push_back(op);
        add_rand(32'(pad));
        add_rand(4);
        add_word(w1);
        if (op == OP_TABLESWITCH) add_word(w2);
        add_rand(body);
    endtask

    task automatic flush_method(input logic trunc);
        int cut;
        if (trunc && mbytes.size() - last_start > 1) begin
            cut = $urandom_range(1, mbytes.size() - last_start - 1);
            repeat (cut) void'(mbytes.pop_back());
        end
        for (int i = 0; i < mbytes.size(); i++) push_byte(mbytes[i], i == mbytes.size() - 1);
        mbytes.delete();
        last_start = 0;
    endtask

    function automatic logic [7:0] rand_fixed_op();
        logic [7:0] op;
        do op = 8'($urandom_range(0, 255)); while (instr_kind(op) > K_MAX_FIXED);
        return op;
    endfunction

    task automatic add_random_instr();
        int unsigned r;
        int          lo;
        int unsigned span;
        logic [7:0]  op;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] tmp;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            add_fixed(rand_fixed_op());
        end else if (r < 66) begin
            last_start = mbytes.size();
            mbytes.push_back(OP_WIDE);
            mbytes.push_back(OP_IINC);
            add_rand(4);
        end else if (r < 74) begin
            lo   = int'($urandom_range(0, 40)) - 20;
            span = $urandom_range(0, 4);
            add_switch(OP_TABLESWITCH, lo, lo + int'(span), (span + 1) * 4);
        end else if (r < 82) begin
            span = $urandom_range(0, 4);
            add_switch(OP_LOOKUPSWITCH, span, 32'd0, span * 8);
        end else if (r < 85) begin
            do op = 8'($urandom_range(0, 255)); while (instr_kind(op) != K_INV);
            last_start = mbytes.size();
            mbytes.push_back(op);
        end else if (r < 88) begin
            do op = 8'($urandom_range(0, 255)); while (op == OP_IINC);
            last_start = mbytes.size();
            mbytes.push_back(OP_WIDE);
            mbytes.push_back(op);
        end else if (r < 91) begin
            // high strictly below low
            w1 = $urandom;
            w2 = $urandom;
            if ($signed(w2) > $signed(w1)) begin
                tmp = w1;
                w1  = w2;
                w2  = tmp;
            end
            if (w1 == w2) begin
                w1 = 32'd1;
                w2 = 32'hFFFF_FFF0;
            end
            add_switch(OP_TABLESWITCH, w1, w2, 0);
        end else if (r < 93) begin
            add_switch(OP_LOOKUPSWITCH, $urandom | 32'h8000_0000, 32'd0, 0);
        end else begin
            last_start = mbytes.size();
            add_rand(1);
        end
    endtask

    initial begin : stimulus
        logic [1:0]  base_plan[6];
        int unsigned goal;
        logic        drained;
        base_plan = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1};
        drained   = 1'b0;

        set_base(2'd0);
        // well-formed: nop, sipush of all ones, wide iinc, empty lookupswitch on the last byte
        mbytes.push_back(8'h00);
        mbytes.push_back(8'h11);
        mbytes.push_back(8'hFF);
        mbytes.push_back(8'hFF);
        mbytes.push_back(OP_WIDE);
        mbytes.push_back(OP_IINC);
        add_rand(4);
        add_switch(OP_LOOKUPSWITCH, 32'd0, 32'd0, 0);
        flush_method(1'b0);
        // invalid opcode, the rest of the method is dropped
        mbytes.push_back(8'hFF);
        add_rand(3);
        flush_method(1'b0);
        // wide ahead of something other than iinc
        mbytes.push_back(OP_WIDE);
        mbytes.push_back(8'h10);
        mbytes.push_back(8'h00);
        flush_method(1'b0);
        // tableswitch with high below low at the signed extremes
        add_switch(OP_TABLESWITCH, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_rand(2);
        flush_method(1'b0);
        // negative pair count detected on the final byte
        add_switch(OP_LOOKUPSWITCH, 32'h8000_0000, 32'd0, 0);
        flush_method(1'b0);
        // widest possible range, table cut short by the end of code
        add_switch(OP_TABLESWITCH, 32'h8000_0000, 32'h7FFF_FFFF, 3);
        flush_method(1'b0);
        // operands cut short, then a lone invalid opcode
        mbytes.push_back(8'hC8);
        mbytes.push_back(8'h01);
        flush_method(1'b0);
        mbytes.push_back(8'hBA);
        flush_method(1'b0);
        set_base(2'd3);
        mbytes.push_back(8'h00);
        add_switch(OP_TABLESWITCH, 32'd5, 32'd5, 4);
        flush_method(1'b0);

        // long lookupswitch sent back to back
        tx_calm = 1'b1;
        add_fixed(8'h00);
        add_switch(OP_LOOKUPSWITCH, 32'd16, 32'd0, 16 * 8);
        add_fixed(8'h00);
        add_fixed(8'h00);
        flush_method(1'b0);

        for (int p = 0; p < 6; p++) begin
            set_base(base_plan[p]);
            if (p == 2) begin
                // receiver stalls while the sender keeps pushing
                push_marker(SEQ_HOLD, 8'd0);
                tx_calm = 1'b1;
                repeat (40) add_fixed(rand_fixed_op());
                flush_method(1'b0);
            end
            goal = n_queued + 240;
            while (n_queued < goal) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    add_rand($urandom_range(1, 20));
                    flush_method(1'b0);
                end else begin
                    repeat ($urandom_range(1, 10)) add_random_instr();
                    flush_method($urandom_range(0, 99) < 15);
                end
                if (p == 4 && !drained) begin
                    push_marker(SEQ_DRAIN, 8'd0);
                    drained = 1'b1;
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (code_stream.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (decoded_instrs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (decoded_instrs.size() != 0)
            report_mismatch("instructions never reported", decoded_instrs.size(), 32'd0);

        $display("decoded %0d code bytes into %0d instructions, %0d base phase writes",
                 bytes_taken, results_checked, cfg_writes);
        $display("status ok %0d, invalid %0d, bad wide %0d, truncated %0d, negative range %0d",
                 n_status[ST_OK], n_status[ST_INVALID], n_status[ST_BAD_WIDE],
                 n_status[ST_TRUNCATED], n_status[ST_NEG_RANGE]);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
